// File: rtl/software_timer_pool_macros.svh
// Assertion macros for the timer pool.
`ifndef SOFTWARE_TIMER_POOL_MACROS_SVH
`define SOFTWARE_TIMER_POOL_MACROS_SVH
`ifndef SYNTHESIS
`define STP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STP_ASSERT(label, clk, rst_n, prop, msg)
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/stp_pkg.sv
// Shared types and constants of the timer pool.
package stp_pkg;
    localparam int NUM_TIMERS = 31;
    localparam int TOP_ID = (NUM_TIMERS < 31) ? NUM_TIMERS : 31;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_POLL  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] SCALE_US = 2'd0;
    localparam logic [1:0] SCALE_MS = 2'd1;
    localparam logic [1:0] SCALE_S  = 2'd2;

    localparam logic [1:0] REG_TICK_US = 2'd0;
    localparam logic [1:0] REG_TICK_MS = 2'd1;
    localparam logic [1:0] REG_TICK_S  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MUL, ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage

// File: rtl/stp_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module stp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stp_pkg::t_div_req i_req,
    output stp_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_quo = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
            n_cnt = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial[32]) begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end else begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: rtl/stp_timer_ram.sv
// Per-timer store: start tick and duration, one write and one registered read.
module stp_timer_ram (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [63:0] i_wdata,
    input  logic [4:0]  i_raddr,
    output logic [63:0] o_rdata
);
    logic [63:0] r_mem [32];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/software_timer_pool.sv
// Timer pool top level: command sequencer, tick counter and allocation mask.
// Accept to result valid runs through the read, execute and output states, with a
// multiply state for a granted start in ms, s or an unknown unit and a divide state
// for a granted start in us or a running read in ms or s; one command at a time.
// Synchronous active-low reset clears the mask, counter and registers to defaults;
// timer store contents stay undefined until written.
module software_timer_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [4:0]  i_timer_id,
    input  logic [31:0] i_target_value,
    input  logic [1:0]  i_time_scale,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_timer_id_out,
    output logic        o_finished,
    output logic [31:0] o_elapsed_value,
    output logic        o_is_running,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    `include "software_timer_pool_macros.svh"

    localparam int TOPW = stp_pkg::TOP_ID;

    stp_pkg::t_state r_state, n_state;
    logic [15:0] r_tick_us, r_tick_ms;
    logic [23:0] r_tick_s;
    logic [31:0] r_tick_count;
    logic [TOPW-1:0] r_mask;
    logic [2:0]  r_cmd;
    logic [4:0]  r_id, r_id_out;
    logic [31:0] r_target, r_elapsed, r_prod;
    logic [1:0]  r_scale;
    logic        r_fin, r_ovalid;

    logic        ram_we;
    logic [4:0]  ram_waddr;
    logic [63:0] ram_wdata, ram_rdata;
    stp_pkg::t_div_req div_req;
    stp_pkg::t_div_rsp div_rsp;

    logic        accept, id_run, free_found;
    logic [4:0]  free_id;
    logic [31:0] ticks, div_d, div_n;
    logic [31:0] prod_full;

    stp_timer_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_id),
        .o_rdata(ram_rdata)
    );

    stp_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    function automatic logic running(input logic [TOPW-1:0] m, input logic [4:0] id);
        logic r;
        r = 1'b0;
        for (int k = 1; k <= TOPW; k++) begin
            if (id == 5'(k)) r = m[k-1];
        end
        return r;
    endfunction

    always_comb begin
        free_found = 1'b0;
        free_id = '0;
        for (int k = TOPW; k >= 1; k--) begin
            if (!r_mask[k-1]) begin
                free_found = 1'b1;
                free_id = 5'(k);
            end
        end
    end

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != stp_pkg::ST_IDLE);
    assign id_run = running(r_mask, r_id);
    assign ticks = r_tick_count - ram_rdata[31:0];

    // Dividend and divisor for us start and ms/s read.
    always_comb begin
        if (r_cmd == stp_pkg::CMD_START) begin
            div_n = r_target;
            div_d = (r_tick_us == '0) ? 32'd1 : {16'd0, r_tick_us};
        end else if (r_scale == stp_pkg::SCALE_MS) begin
            div_d = (r_tick_ms == '0) ? 32'd1 : {16'd0, r_tick_ms};
            div_n = ticks + {1'b0, div_d[31:1]};
        end else begin
            div_d = (r_tick_s == '0) ? 32'd1 : {8'd0, r_tick_s};
            div_n = ticks + {1'b0, div_d[31:1]};
        end
    end

    // Only the low word of the product is kept, so the duration wraps mod 2^32.
    always_comb begin
        unique case (r_scale)
            stp_pkg::SCALE_US: prod_full = '0;
            stp_pkg::SCALE_MS: prod_full = r_target * {16'd0, r_tick_ms};
            stp_pkg::SCALE_S:  prod_full = r_target * {8'd0, r_tick_s};
            default:           prod_full = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stp_pkg::ST_IDLE: if (accept) n_state = stp_pkg::ST_READ;
            stp_pkg::ST_READ: n_state = stp_pkg::ST_EXEC;
            stp_pkg::ST_EXEC: begin
                n_state = stp_pkg::ST_OUT;
                if (r_cmd == stp_pkg::CMD_START && r_id_out != '0) begin
                    n_state = (r_scale == stp_pkg::SCALE_US) ? stp_pkg::ST_DIV
                                                             : stp_pkg::ST_MUL;
                end else if (r_cmd == stp_pkg::CMD_READ && id_run &&
                             (r_scale == stp_pkg::SCALE_MS || r_scale == stp_pkg::SCALE_S)) begin
                    n_state = stp_pkg::ST_DIV;
                end
            end
            stp_pkg::ST_DIV: if (div_rsp.done) n_state = stp_pkg::ST_OUT;
            stp_pkg::ST_MUL: n_state = stp_pkg::ST_OUT;
            stp_pkg::ST_OUT: if (!i_stall) n_state = stp_pkg::ST_IDLE;
            default: n_state = stp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        div_req = '0;
        ram_we = 1'b0;
        ram_waddr = r_id_out;
        ram_wdata = {r_prod, r_tick_count};
        unique case (r_state)
            stp_pkg::ST_EXEC: begin
                div_req.dividend = div_n;
                div_req.divisor = div_d;
                div_req.start = (n_state == stp_pkg::ST_DIV);
                if (r_cmd == stp_pkg::CMD_START && r_id_out != '0 &&
                    r_scale != stp_pkg::SCALE_US && r_scale != stp_pkg::SCALE_MS &&
                    r_scale != stp_pkg::SCALE_S) begin
                    ram_we = 1'b1;
                    ram_wdata = {32'd0, r_tick_count};
                end
            end
            stp_pkg::ST_DIV: begin
                ram_we = div_rsp.done && r_cmd == stp_pkg::CMD_START;
                ram_wdata = {div_rsp.quotient, r_tick_count};
            end
            stp_pkg::ST_MUL: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_id <= i_timer_id;
            r_target <= i_target_value;
            r_scale <= i_time_scale;
            r_id_out <= i_timer_id;
            r_fin <= 1'b0;
            r_elapsed <= '0;
        end
        r_prod <= prod_full;
        if (r_state == stp_pkg::ST_DIV && div_rsp.done && r_cmd == stp_pkg::CMD_READ) begin
            r_elapsed <= div_rsp.quotient;
        end
        if (!i_rst_n) begin
            r_state <= stp_pkg::ST_IDLE;
            r_tick_us <= 16'd100;
            r_tick_ms <= 16'd10;
            r_tick_s <= 24'd10000;
            r_tick_count <= '0;
            r_mask <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stp_pkg::REG_TICK_US: r_tick_us <= i_cfg_data[15:0];
                    stp_pkg::REG_TICK_MS: r_tick_ms <= i_cfg_data[15:0];
                    stp_pkg::REG_TICK_S:  r_tick_s <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == stp_pkg::ST_READ) begin
                // Mask and id settle here; data from the store arrives next cycle.
                priority if (r_cmd == stp_pkg::CMD_TICK) begin
                    if (r_mask != '0) r_tick_count <= r_tick_count + 32'd1;
                end else if (r_cmd == stp_pkg::CMD_START && !id_run) begin
                    if (free_found) begin
                        r_mask[free_id-5'd1] <= 1'b1;
                        r_id_out <= free_id;
                    end else begin
                        r_id_out <= '0;
                    end
                end else if (r_cmd == stp_pkg::CMD_STOP && id_run) begin
                    r_mask[r_id-5'd1] <= 1'b0;
                    r_id_out <= '0;
                    if ((r_mask & ~(TOPW'(1) << (r_id - 5'd1))) == '0) r_tick_count <= '0;
                end
            end
            if (r_state == stp_pkg::ST_EXEC && r_cmd == stp_pkg::CMD_POLL && id_run &&
                ticks >= ram_rdata[63:32]) begin
                r_mask[r_id-5'd1] <= 1'b0;
                r_id_out <= '0;
                r_fin <= 1'b1;
                if ((r_mask & ~(TOPW'(1) << (r_id - 5'd1))) == '0) r_tick_count <= '0;
            end
            if (r_state == stp_pkg::ST_EXEC && r_cmd == stp_pkg::CMD_READ && id_run &&
                r_scale == stp_pkg::SCALE_US) begin
                r_elapsed <= 32'(ticks * {16'd0, r_tick_us});
            end
            r_ovalid <= (n_state == stp_pkg::ST_OUT);
        end
    end

    assign o_valid = r_ovalid;
    assign o_timer_id_out = r_id_out;
    assign o_finished = r_fin;
    assign o_elapsed_value = r_elapsed;
    assign o_is_running = running(r_mask, r_id_out);

    `STP_ASSERT(a_valid_out_state, i_clk, i_rst_n, !o_valid || r_state == stp_pkg::ST_OUT, "result valid outside output state")
    `STP_ASSERT(a_fin_frees, i_clk, i_rst_n, !(o_valid && o_finished) || (o_timer_id_out == '0 && !o_is_running), "finished timer still held")
    `STP_ASSERT(a_count_idle, i_clk, i_rst_n, r_mask != '0 || r_tick_count == '0, "tick count nonzero with no timer active")
    `STP_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, div_req.start, r_state == stp_pkg::ST_DIV && div_rsp.busy, "divider not running after start")
endmodule

// File: bench/software_timer_pool_checker.sv
// Checker for the timer pool: watches both channels, predicts each result and compares.
module software_timer_pool_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [2:0]  i_command,
    input  logic [4:0]  i_timer_id,
    input  logic [31:0] i_target_value,
    input  logic [1:0]  i_time_scale,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [4:0]  i_timer_id_out,
    input  logic        i_finished,
    input  logic [31:0] i_elapsed_value,
    input  logic        i_is_running,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [4:0]  id;
        logic        fin;
        logic [31:0] elapsed;
        logic        running;
    } t_timer_result;

    t_timer_result expected_q[$];
    logic [31:0] period_us, per_ms, per_s;
    logic [31:0] ticks;
    logic [30:0] active;
    logic [31:0] started_at [32];
    logic [31:0] dur_ticks [32];

    assign o_pending = expected_q.size();

    function automatic logic is_active(logic [4:0] id);
        if (id == 0 || id > stp_pkg::TOP_ID) return 1'b0;
        return active[id-1];
    endfunction

    function automatic logic [31:0] nonzero(logic [31:0] v);
        return (v == 0) ? 32'd1 : v;
    endfunction

    task automatic release_timer(logic [4:0] id);
        active[id-1] = 1'b0;
        if (active == 0) ticks = 0;
    endtask

    task automatic predict_command(logic [2:0] cmd, logic [4:0] id, logic [31:0] target,
                                   logic [1:0] scale);
        t_timer_result r;
        logic [31:0] dt, d;
        int k;
        r = '{id: id, fin: 1'b0, elapsed: 32'd0, running: 1'b0};
        case (cmd)
            stp_pkg::CMD_TICK: if (active != 0) ticks = ticks + 1;
            stp_pkg::CMD_START: begin
                if (!is_active(id)) begin
                    k = 1;
                    while (k <= stp_pkg::TOP_ID && active[k-1]) k++;
                    if (k <= stp_pkg::TOP_ID) begin
                        active[k-1] = 1'b1;
                        r.id = k[4:0];
                    end else begin
                        r.id = 5'd0;
                    end
                end
                if (r.id != 0) begin
                    case (scale)
                        stp_pkg::SCALE_US: d = target / nonzero(period_us);
                        stp_pkg::SCALE_MS: d = target * per_ms;
                        stp_pkg::SCALE_S:  d = target * per_s;
                        default:           d = 32'd0;
                    endcase
                    started_at[r.id] = ticks;
                    dur_ticks[r.id] = d;
                end
            end
            stp_pkg::CMD_STOP: if (is_active(id)) begin
                release_timer(id);
                r.id = 5'd0;
            end
            stp_pkg::CMD_POLL: if (is_active(id)) begin
                dt = ticks - started_at[id];
                if (dt >= dur_ticks[id]) begin
                    release_timer(id);
                    r.fin = 1'b1;
                    r.id = 5'd0;
                end
            end
            stp_pkg::CMD_READ: if (is_active(id)) begin
                dt = ticks - started_at[id];
                case (scale)
                    stp_pkg::SCALE_US: r.elapsed = dt * period_us;
                    stp_pkg::SCALE_MS: begin
                        d = nonzero(per_ms);
                        r.elapsed = (dt + d / 2) / d;
                    end
                    stp_pkg::SCALE_S: begin
                        d = nonzero(per_s);
                        r.elapsed = (dt + d / 2) / d;
                    end
                    default: r.elapsed = 32'd0;
                endcase
            end
            default: ;
        endcase
        r.running = is_active(r.id);
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_timer_result e;
        if (!i_rst_n) begin
            period_us <= 100;
            per_ms <= 10;
            per_s <= 10000;
            ticks = 0;
            active = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stp_pkg::REG_TICK_US: period_us <= {16'd0, i_cfg_data[15:0]};
                    stp_pkg::REG_TICK_MS: per_ms <= {16'd0, i_cfg_data[15:0]};
                    stp_pkg::REG_TICK_S:  per_s <= {8'd0, i_cfg_data};
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", 32'd0, 32'd0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_timer_id_out !== e.id)
                        report_mismatch("timer_id_out", 32'(i_timer_id_out), 32'(e.id));
                    if (i_finished !== e.fin)
                        report_mismatch("finished", 32'(i_finished), 32'(e.fin));
                    if (i_elapsed_value !== e.elapsed)
                        report_mismatch("elapsed_value", i_elapsed_value, e.elapsed);
                    if (i_is_running !== e.running)
                        report_mismatch("is_running", 32'(i_is_running), 32'(e.running));
                end
            end
            if (i_valid && !i_stall_in)
                predict_command(i_command, i_timer_id, i_target_value, i_time_scale);
        end
    end
endmodule

// File: bench/testbench.sv
// Top of the timer pool bench: clock, reset, stimulus and verdict.
module testbench;
    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic        o_stall, o_valid;
    logic [2:0]  i_command = 0;
    logic [4:0]  i_timer_id = 0;
    logic [31:0] i_target_value = 0;
    logic [1:0]  i_time_scale = 0;
    logic [4:0]  o_timer_id_out;
    logic        o_finished, o_is_running;
    logic [31:0] o_elapsed_value;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;
    int          errors, pending;
    int          send_idle_pct, recv_idle_pct;

    software_timer_pool i_dut (.*);

    software_timer_pool_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_command, .i_timer_id,
        .i_target_value, .i_time_scale, .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_timer_id_out(o_timer_id_out), .i_finished(o_finished),
        .i_elapsed_value(o_elapsed_value), .i_is_running(o_is_running),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // One beat: random idle gaps before, then hold until accepted.
    // Valid stays high after the accepting edge; the next call or drain lowers it.
    task automatic send_beat(logic [2:0] cmd, logic [4:0] id, logic [31:0] tgt,
                             logic [1:0] scale);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd;
        i_timer_id <= id;
        i_target_value <= tgt;
        i_time_scale <= scale;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Write enable stays high; the caller lowers it after the last write.
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Mostly starts, ticks, polls and reads on low ids so timers live and expire.
    task automatic random_beat;
        logic [2:0] cmd;
        logic [4:0] id;
        logic [31:0] tgt;
        logic [1:0] scale;
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) cmd = stp_pkg::CMD_TICK;
        else if (pick < 55) cmd = stp_pkg::CMD_START;
        else if (pick < 65) cmd = stp_pkg::CMD_STOP;
        else if (pick < 80) cmd = stp_pkg::CMD_POLL;
        else if (pick < 97) cmd = stp_pkg::CMD_READ;
        else cmd = 3'($urandom_range(7, 5));
        id = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(6));
        case ($urandom_range(3))
            0: tgt = $urandom;
            1: tgt = $urandom_range(3000);
            default: tgt = $urandom_range(8);
        endcase
        scale = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        send_beat(cmd, id, tgt, scale);
    endtask

    initial begin
        int k;
        send_idle_pct = 15;
        recv_idle_pct = 67;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: every command, unit and corner at reset settings.
        send_beat(stp_pkg::CMD_TICK, 5'd0, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_START, 5'd0, 32'hFFFF_FFFF, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_START, 5'd31, 32'd2, stp_pkg::SCALE_MS);
        send_beat(stp_pkg::CMD_START, 5'd1, 32'd0, 2'd3);
        send_beat(stp_pkg::CMD_POLL, 5'd1, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_TICK, 5'd0, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_READ, 5'd2, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_READ, 5'd2, 32'd0, stp_pkg::SCALE_MS);
        send_beat(stp_pkg::CMD_READ, 5'd2, 32'd0, stp_pkg::SCALE_S);
        send_beat(stp_pkg::CMD_READ, 5'd2, 32'd0, 2'd3);
        send_beat(stp_pkg::CMD_READ, 5'd9, 32'd0, stp_pkg::SCALE_MS);
        send_beat(stp_pkg::CMD_POLL, 5'd2, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_STOP, 5'd2, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_STOP, 5'd2, 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_START, 5'd0, 32'hFFFF_FFFF, stp_pkg::SCALE_S);
        send_beat(3'd7, 5'd31, 32'd0, stp_pkg::SCALE_US);
        send_beat(3'd5, 5'd1, 32'd0, stp_pkg::SCALE_US);
        // fill, overflow
        for (k = 0; k < 32; k++) send_beat(stp_pkg::CMD_START, 5'd0, 32'd5, stp_pkg::SCALE_MS);
        send_beat(stp_pkg::CMD_STOP, 5'd31, 32'd0, stp_pkg::SCALE_US);
        for (k = 1; k <= 31; k++) send_beat(stp_pkg::CMD_STOP, 5'(k), 32'd0, stp_pkg::SCALE_US);
        send_beat(stp_pkg::CMD_TICK, 5'd0, 32'd0, stp_pkg::SCALE_US);
        drain();

        // Register extremes, including zero divisors.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(stp_pkg::REG_TICK_US, 24'd0);
                    write_reg(stp_pkg::REG_TICK_MS, 24'd0);
                    write_reg(stp_pkg::REG_TICK_S, 24'd0);
                end
                1: begin
                    write_reg(stp_pkg::REG_TICK_US, 24'hFFFF);
                    write_reg(stp_pkg::REG_TICK_MS, 24'hFFFF);
                    write_reg(stp_pkg::REG_TICK_S, 24'hFFFFFF);
                end
                2: begin
                    write_reg(stp_pkg::REG_TICK_US, 24'd1);
                    write_reg(stp_pkg::REG_TICK_MS, 24'd1);
                    write_reg(stp_pkg::REG_TICK_S, 24'd1);
                end
                3: begin
                    write_reg(stp_pkg::REG_TICK_US, 24'd3);
                    write_reg(stp_pkg::REG_TICK_MS, 24'd2);
                    write_reg(stp_pkg::REG_TICK_S, 24'd5);
                end
                default: begin
                    write_reg(stp_pkg::REG_TICK_US, 24'($urandom));
                    write_reg(stp_pkg::REG_TICK_MS, 24'($urandom));
                    write_reg(stp_pkg::REG_TICK_S, 24'($urandom_range(40)));
                end
            endcase
            i_cfg_we <= 0;
            if (ph == 2) begin
                send_idle_pct = 67;
                recv_idle_pct = 15;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (k = 0; k < 300; k++) begin
                random_beat();
                if (k == 150) begin
                    i_valid <= 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_divider.sv
rtl/stp_timer_ram.sv
rtl/software_timer_pool.sv
bench/software_timer_pool_checker.sv
bench/testbench.sv
